// ----- rtl/dpq_pkg.sv -----
// Package for the dedup priority queue: widths, codes and shared types.
// No dependencies; used by the interfaces, the cell and the top level.
package dpq_pkg;

  localparam int KEY_W          = 32;
  localparam int PRIO_W         = 8;
  localparam int STATUS_W       = 3;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } dpq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } dpq_status_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } dpq_slot_t;

  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } dpq_cmd_t;

  typedef struct packed {
    logic hit;
    logic ge;
  } dpq_flags_t;

endpackage

// ----- rtl/dpq_if.sv -----
// Valid/ready channel interfaces for the queue's input and result words.
// Depends on dpq_pkg for field widths.
interface dpq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [dpq_pkg::KEY_W-1:0]  entry_key;
  logic [dpq_pkg::PRIO_W-1:0] entry_priority;

  modport source (output valid, output operation, output entry_key,
                  output entry_priority, input ready);
  modport sink   (input valid, input operation, input entry_key,
                  input entry_priority, output ready);
endinterface

interface dpq_out_if;
  logic                         valid;
  logic                         ready;
  logic [dpq_pkg::STATUS_W-1:0] status;
  logic [dpq_pkg::KEY_W-1:0]    out_key;
  logic [dpq_pkg::PRIO_W-1:0]   out_priority;

  modport source (output valid, output status, output out_key,
                  output out_priority, input ready);
  modport sink   (input valid, input status, input out_key,
                  input out_priority, output ready);
endinterface

// ----- rtl/dpq_cell.sv -----
// One slot of the sorted queue chain: holds an entry, compares it with the
// command word and shifts toward or away from the head. Depends on dpq_pkg.
module dpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_pkg::dpq_cmd_t  cmd,
  input  dpq_pkg::dpq_slot_t left_slot,
  input  logic               left_ge,
  input  dpq_pkg::dpq_slot_t right_slot,
  output dpq_pkg::dpq_slot_t slot,
  output dpq_pkg::dpq_flags_t flags
);

  dpq_pkg::dpq_slot_t slot_r, slot_nxt;

  always_comb begin
    flags.hit = slot_r.valid && (slot_r.key == cmd.key);
    flags.ge  = slot_r.valid && (slot_r.prio >= cmd.prio);
    slot_nxt  = slot_r;
    if (cmd.enq && !flags.ge) begin
      if (left_ge) begin
        slot_nxt.valid = 1'b1;
        slot_nxt.key   = cmd.key;
        slot_nxt.prio  = cmd.prio;
      end else begin
        slot_nxt = left_slot;
      end
    end else if (cmd.deq) begin
      slot_nxt = right_slot;
    end
  end

  // valid resets, payload does not
  always_ff @(posedge clk) begin
    slot_r.key  <= slot_nxt.key;
    slot_r.prio <= slot_nxt.prio;
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

  assign slot = slot_r;

endmodule

// ----- rtl/dedup_priority_queue_top.sv -----
// Dedup priority queue top level: input register, chain of dpq_cell slots
// and the result register. Depends on dpq_pkg, dpq_if and dpq_cell.
//
// Usage:
//   in_ch  carries one word per request: operation (0 enqueue, 1 dequeue),
//          entry_key and entry_priority. Taken when valid and ready are high.
//   out_ch returns one word per request: status, out_key, out_priority.
//   Each request is held in the input register, then every cell
//   compares its entry against it in parallel, the duplicate flags are ORed
//   and the whole chain inserts or shifts in that same cycle.
//   Throughput: one request per cycle while out_ch keeps up; the limit is
//   the compare, OR over QUEUE_DEPTH cells and slot mux in the apply cycle.
//   Stall: while a result word waits on out_ch the held request waits too,
//   and with a request held in_ch.ready drops until the result register frees.
//   Reset (rst_n low, synchronous) empties every slot and drops both
//   valid flags; slot contents are not cleared.
module dedup_priority_queue_top #(
  parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  dpq_in_if.sink    in_ch,
  dpq_out_if.source out_ch
);

  logic                         busy_r, busy_nxt;
  dpq_pkg::dpq_op_t             op_r;
  logic [dpq_pkg::KEY_W-1:0]    key_r;
  logic [dpq_pkg::PRIO_W-1:0]   prio_r;

  logic                         out_valid_r, out_valid_nxt;
  dpq_pkg::dpq_status_t         out_status_r, status_nxt;
  logic [dpq_pkg::KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [dpq_pkg::PRIO_W-1:0]   out_prio_r, out_prio_nxt;

  logic out_free, fire, accept, hit_any, full;

  dpq_pkg::dpq_cmd_t   cmd;
  dpq_pkg::dpq_slot_t  slots [QUEUE_DEPTH];
  dpq_pkg::dpq_flags_t flags [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit_vec;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign fire        = busy_r && out_free;
  assign in_ch.ready = !busy_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_vec[i] = flags[i].hit;
    end
  end

  assign hit_any = |hit_vec;
  assign full    = slots[QUEUE_DEPTH-1].valid;

  always_comb begin
    cmd.key  = key_r;
    cmd.prio = prio_r;
    cmd.enq  = fire && (op_r == dpq_pkg::OP_ENQ) && !hit_any && !full;
    cmd.deq  = fire && (op_r == dpq_pkg::OP_DEQ) && slots[0].valid;
  end

  generate
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      dpq_pkg::dpq_slot_t left_slot, right_slot;
      logic               left_ge;
      if (g == 0) begin : g_head
        assign left_slot = '0;
        assign left_ge   = 1'b1;
      end else begin : g_mid
        assign left_slot = slots[g-1];
        assign left_ge   = flags[g-1].ge;
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_body
        assign right_slot = slots[g+1];
      end
      dpq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .left_slot  (left_slot),
        .left_ge    (left_ge),
        .right_slot (right_slot),
        .slot       (slots[g]),
        .flags      (flags[g])
      );
    end
  endgenerate

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (fire) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_key_nxt  = '0;
    out_prio_nxt = '0;
    if (op_r == dpq_pkg::OP_DEQ) begin
      if (slots[0].valid) begin
        status_nxt   = dpq_pkg::ST_DEQUEUED;
        out_key_nxt  = slots[0].key;
        out_prio_nxt = slots[0].prio;
      end else begin
        status_nxt = dpq_pkg::ST_EMPTY;
      end
    end else if (hit_any) begin
      status_nxt = dpq_pkg::ST_DUP;
    end else if (full) begin
      status_nxt = dpq_pkg::ST_FULL;
    end else begin
      status_nxt = dpq_pkg::ST_QUEUED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold request and result payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= dpq_pkg::dpq_op_t'(in_ch.operation);
      key_r  <= in_ch.entry_key;
      prio_r <= in_ch.entry_priority;
    end
    if (fire) begin
      out_status_r <= status_nxt;
      out_key_r    <= out_key_nxt;
      out_prio_r   <= out_prio_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_key      = out_key_r;
  assign out_ch.out_priority = out_prio_r;

endmodule

// ----- verif/dedup_priority_queue_top_test.sv -----
`timescale 1ns / 100ps
// Testbench for dedup_priority_queue_top: drives enqueue/dequeue words, predicts each
// result with a sorted-queue model and checks every result word field by field.
// Depends on dpq_pkg, dpq_if and the queue RTL.
module dedup_priority_queue_top_test;

  localparam int DEPTH       = dpq_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 107;

  typedef struct {
    dpq_pkg::dpq_op_t           op;
    logic [dpq_pkg::KEY_W-1:0]  key;
    logic [dpq_pkg::PRIO_W-1:0] prio;
    int                         tx_idle_pct;
    int                         rx_stall_pct;
    bit                         hold_until_drained;
  } queue_request_t;

  typedef struct {
    dpq_pkg::dpq_status_t       status;
    logic [dpq_pkg::KEY_W-1:0]  key;
    logic [dpq_pkg::PRIO_W-1:0] prio;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dpq_in_if  in_ch();
  dpq_out_if out_ch();

  dedup_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  queue_request_t             pending_requests[$];
  queue_result_t              expected_results[$];
  logic [dpq_pkg::KEY_W-1:0]  held_key[DEPTH];
  logic [dpq_pkg::PRIO_W-1:0] held_prio[DEPTH];
  int                         held_count = 0;
  int                         rx_stall_pct = 0;
  int                         error_count = 0;
  int                         cycle_count = 0;
  logic [dpq_pkg::KEY_W-1:0]  key_pool[POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 50) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic queue_result_t predict_queue_result(queue_request_t rq);
    queue_result_t r;
    int            pos;
    bit            dup;
    r.status = dpq_pkg::ST_QUEUED;
    r.key    = '0;
    r.prio   = '0;
    dup      = 1'b0;
    if (rq.op == dpq_pkg::OP_DEQ) begin
      if (held_count == 0) begin
        r.status = dpq_pkg::ST_EMPTY;
      end else begin
        r.status = dpq_pkg::ST_DEQUEUED;
        r.key    = held_key[0];
        r.prio   = held_prio[0];
        for (int i = 0; i + 1 < held_count; i++) begin
          held_key[i]  = held_key[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held_count--;
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (held_key[i] == rq.key) dup = 1'b1;
      end
      if (dup) begin
        r.status = dpq_pkg::ST_DUP;
      end else if (held_count == DEPTH) begin
        r.status = dpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] >= rq.prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_key[i]  = held_key[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_key[pos]  = rq.key;
        held_prio[pos] = rq.prio;
        held_count++;
      end
    end
    return r;
  endfunction

  function automatic void push_request(dpq_pkg::dpq_op_t op, logic [dpq_pkg::KEY_W-1:0] key,
                                       logic [dpq_pkg::PRIO_W-1:0] prio, int tx_pct,
                                       int rx_pct, bit drain);
    queue_request_t rq;
    rq.op                 = op;
    rq.key                = key;
    rq.prio               = prio;
    rq.tx_idle_pct        = tx_pct;
    rq.rx_stall_pct       = rx_pct;
    rq.hold_until_drained = drain;
    pending_requests.push_back(rq);
  endfunction

  always @(posedge clk) begin : drive_requests
    bit keep;
    bit offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      keep = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_queue_result(pending_requests[0]));
        rx_stall_pct <= pending_requests[0].rx_stall_pct;
        void'(pending_requests.pop_front());
        keep = 1'b0;
      end
      if (keep) begin
        offer = 1'b1;
      end else if (pending_requests.size() == 0) begin
        offer = 1'b0;
      end else if (pending_requests[0].hold_until_drained && expected_results.size() != 0) begin
        offer = 1'b0;
      end else begin
        offer = ($urandom_range(99) >= pending_requests[0].tx_idle_pct);
      end
      in_ch.valid <= offer;
      if (offer && !keep) begin
        in_ch.operation      <= pending_requests[0].op;
        in_ch.entry_key      <= pending_requests[0].key;
        in_ch.entry_priority <= pending_requests[0].prio;
      end
    end
  end

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d key %h prio %h",
                                    out_ch.status, out_ch.out_key, out_ch.out_priority));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.out_key !== want.key)
            report_mismatch($sformatf("out_key got %h expected %h",
                                      out_ch.out_key, want.key));
          if (out_ch.out_priority !== want.prio)
            report_mismatch($sformatf("out_priority got %h expected %h",
                                      out_ch.out_priority, want.prio));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                         tx_pct[4];
    int                         rx_pct[4];
    int                         enq_pct[3];
    int                         made;
    int                         seg_len;
    int                         seg_kind;
    int                         sel;
    logic [dpq_pkg::KEY_W-1:0]  key;
    logic [dpq_pkg::PRIO_W-1:0] prio;
    dpq_pkg::dpq_op_t           op;

    tx_pct  = '{0, 82, 0, 28};
    rx_pct  = '{0, 0, 82, 28};
    enq_pct = '{85, 20, 55};

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = dpq_pkg::OP_ENQ;
    in_ch.entry_key      = '0;
    in_ch.entry_priority = '0;
    out_ch.ready         = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // empty queue, field extremes, ties, full store, duplicate while full
    push_request(dpq_pkg::OP_DEQ, '1, '1, 0, 0, 1'b0);
    push_request(dpq_pkg::OP_ENQ, '0, '0, 0, 0, 1'b0);
    push_request(dpq_pkg::OP_ENQ, '1, '1, 0, 0, 1'b0);
    push_request(dpq_pkg::OP_ENQ, '0, 8'd7, 0, 0, 1'b0);
    for (int i = 0; i < DEPTH - 2; i++) begin
      prio = (i % 4 == 0) ? 8'hFF : (i % 4 == 1) ? 8'h00 : 8'h80;
      push_request(dpq_pkg::OP_ENQ, 32'h1000 + i, prio, 0, 0, 1'b0);
    end
    push_request(dpq_pkg::OP_ENQ, 32'hA5A5_5A5A, 8'hFF, 0, 0, 1'b0);
    push_request(dpq_pkg::OP_ENQ, '1, 8'h01, 0, 0, 1'b0);
    for (int i = 0; i < 4; i++)
      push_request(dpq_pkg::OP_DEQ, $urandom, 8'($urandom_range(255)), 0, 0, i == 0);

    for (int ph = 0; ph < 4; ph++) begin
      made = 0;
      while (made < PHASE_ITEMS) begin
        seg_len  = $urandom_range(6, 24);
        seg_kind = $urandom_range(2);
        for (int j = 0; j < seg_len && made < PHASE_ITEMS; j++) begin
          op  = ($urandom_range(99) < enq_pct[seg_kind]) ? dpq_pkg::OP_ENQ : dpq_pkg::OP_DEQ;
          key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
          sel = $urandom_range(99);
          if (sel < 50) prio = 8'($urandom_range(3));
          else if (sel < 70) prio = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
          else prio = 8'($urandom_range(255));
          push_request(op, key, prio, tx_pct[ph], rx_pct[ph], made == 0);
          made++;
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
